// File: hdl/ictf_pkg.sv
// Shared types and constants of the complementary tilt filter.
// No dependencies; used by the sample interface, the root unit and the top level.
package ictf_pkg;

  localparam int RAW_W        = 16;
  localparam int CFG_W        = 16;
  localparam int RAD_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int ONE_Q15      = 32768;
  localparam int ROT_STEPS    = 6;
  localparam int CORDIC_STEPS = 24;
  localparam int TABLE_FRAC   = 20;
  localparam int ATAN_W       = 27;

  // register indexes of the configuration port
  localparam logic [1:0] REG_LOWPASS    = 2'd0;
  localparam logic [1:0] REG_BLEND      = 2'd1;
  localparam logic [1:0] REG_STEP_SCALE = 2'd2;

  localparam logic [CFG_W-1:0] LOWPASS_RST    = 16'd29491;
  localparam logic [CFG_W-1:0] BLEND_RST      = 16'd32113;
  localparam logic [CFG_W-1:0] STEP_SCALE_RST = 16'd2379;

  // low-pass / blend pass within one vector component
  localparam logic [1:0] MIX_GYRO  = 2'd0;
  localparam logic [1:0] MIX_ACCEL = 2'd1;
  localparam logic [1:0] MIX_FUSED = 2'd2;

  // arctangent of 2^-i in degrees, Q.20
  localparam logic [ATAN_W-1:0] ATAN_DEG_Q20 [CORDIC_STEPS] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
    27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
    27'd234682,   27'd117342,   27'd58671,    27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,
    27'd917,      27'd458,      27'd229,      27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROT_P,
    ST_ROT_S,
    ST_ROT_T,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_ASQ_GO,
    ST_ASQ_WAIT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_MIX_MUL,
    ST_MIX_WR,
    ST_TILT_INIT,
    ST_TILT_MUL,
    ST_TILT_ADD,
    ST_TSQ_GO,
    ST_TSQ_WAIT,
    ST_CORDIC,
    ST_TILT_END,
    ST_DONE
  } state_t;

endpackage

// File: hdl/ictf_if.sv
// Request channels of the tilt filter: IMU sample in, angle pair out.
// Depends on ictf_pkg.
interface ictf_sample_if import ictf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] gyro_x;
  logic signed [RAW_W-1:0] gyro_y;
  logic signed [RAW_W-1:0] gyro_z;
  logic signed [RAW_W-1:0] accel_x;
  logic signed [RAW_W-1:0] accel_y;
  logic signed [RAW_W-1:0] accel_z;

  modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                  input ready);
  modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                output ready);
endinterface

interface ictf_angle_if #(parameter int OUT_W = 16) ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] roll_deg;
  logic signed [OUT_W-1:0] pitch_deg;

  modport source (output valid, roll_deg, pitch_deg, input ready);
  modport sink (input valid, roll_deg, pitch_deg, output ready);
endinterface

// File: hdl/ictf_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on ictf_pkg.
module ictf_isqrt import ictf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0] n;
  logic [RAD_W-1:0] res;
  logic [RAD_W-1:0] bitv;
  logic [RAD_W-1:0] trial;
  logic [4:0]       cnt;
  logic             busy;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(ROOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n    <= radicand;
      res  <= '0;
      bitv <= RAD_W'(1) << (RAD_W - 2);
    end else if (busy) begin
      if (n >= trial) begin
        n   <= n - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// File: hdl/imu_complementary_tilt_filter_top.sv
// Complementary tilt filter: gyro rotation, accel normalisation, blend, roll/pitch.
// Depends on ictf_pkg, ictf_if (ictf_sample_if, ictf_angle_if) and ictf_isqrt.
//
//   channel  | dir | carries                                       | accepted when
//   ---------+-----+-----------------------------------------------+--------------------
//   sample   | in  | gyro_x/y/z, accel_x/y/z (signed 16)           | valid & ready
//   angle    | out | roll_deg, pitch_deg (signed, Q.ANGLE_FRAC)    | valid & ready
//   config   | in  | write_en, reg_index, write_data (16)          | write_en
//
// Each sample is worked through to its angle pair before the next one is taken. A zero accel
// vector skips the root and the divides; a zero angle numerator skips that root and CORDIC.
// Everything runs through one registered multiplier, one 32-step root unit (used three
// times) and a restoring divider of VECTOR_FRAC_BITS+1 steps (used three times), plus
// a 24-step CORDIC per angle. The sample channel is ready only in idle; a finished angle
// pair sits in an output register, so a new sample is taken while it waits. Reset
// (synchronous) restores the weight registers and clears all three kept vectors.
module imu_complementary_tilt_filter_top import ictf_pkg::*; #(
  parameter int VECTOR_FRAC_BITS = 14,
  parameter int ANGLE_FRAC_BITS  = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             write_en,
  input  logic [1:0]       reg_index,
  input  logic [CFG_W-1:0] write_data,
  ictf_sample_if.sink      sample,
  ictf_angle_if.source     angle
);

  localparam int VEC_W = VECTOR_FRAC_BITS + 4;
  localparam int ACC_W = VECTOR_FRAC_BITS + 2;
  localparam int OUT_W = ANGLE_FRAC_BITS + 8;
  // angle inputs are first rounded to Q16 when they carry more fraction bits
  localparam int TD    = (VECTOR_FRAC_BITS > 16) ? VECTOR_FRAC_BITS - 16 : 0;
  localparam int CB    = VEC_W - TD + 1;
  localparam int MA    = VEC_W + 16;
  localparam int MB    = (CB > 17) ? CB : 17;
  localparam int PW    = MA + MB;
  localparam int AW    = (2 * CB + 1 > 33) ? 2 * CB + 1 : 33;
  localparam int QB    = VECTOR_FRAC_BITS + 1;
  localparam int DW    = VECTOR_FRAC_BITS + 34;
  localparam int CW    = CB + 31;
  localparam int ZW    = 29;
  localparam int ROUND_Z   = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int ANG_LIM_I = 90 << ANGLE_FRAC_BITS;
  localparam logic signed [PW-1:0] ANG_LIM = PW'(ANG_LIM_I);

  // round to nearest, ties away from zero
  function automatic logic signed [PW-1:0] rshr(input logic signed [PW-1:0] v,
                                                input int unsigned s);
    logic [PW-1:0] mag;
    logic [PW-1:0] half;
    mag  = v[PW-1] ? PW'(-v) : PW'(v);
    half = (s == 0) ? '0 : (PW'(1) << (s - 1));
    mag  = (mag + half) >> s;
    return v[PW-1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [PW-1:0] sat_w(input logic signed [PW-1:0] v,
                                                 input int unsigned w);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = $signed((PW'(1) << (w - 1)) - PW'(1));
    lo = -hi - PW'(1);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic logic [16:0] weight(input logic [CFG_W-1:0] w);
    return (w > CFG_W'(ONE_Q15)) ? 17'(ONE_Q15) : {1'b0, w};
  endfunction

  state_t state, state_next;

  logic [CFG_W-1:0] lowpass_alpha, blend_alpha, gyro_step_scale;
  logic signed [RAW_W-1:0] gx, gy, gz, ax, ay, az;
  logic signed [VEC_W-1:0] gyro_vec [3];
  logic signed [VEC_W-1:0] fused_vec [3];
  logic signed [VEC_W-1:0] rot [3];
  logic signed [ACC_W-1:0] accel_vec [3];
  logic signed [ACC_W-1:0] an [3];
  logic signed [VEC_W-1:0] t0;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] mul_q;

  logic [4:0] k;
  logic [1:0] mi, mk;
  logic       tp;

  logic [AW-1:0]     acc;
  logic [ROOT_W-1:0] r2;
  logic [DW-1:0]     rem, dsh;
  logic [QB-1:0]     qacc;

  logic signed [CB-1:0] ty_r, ta_r, tb_r;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic signed [OUT_W-1:0] roll_r, pitch_r, roll_q, pitch_q;
  logic out_valid;

  logic              sq_start, sq_done;
  logic [RAD_W-1:0]  sq_rad;
  logic [ROOT_W-1:0] sq_root;

  logic signed [VEC_W-1:0] v_sel;
  logic signed [16:0]      raw_sel;
  logic signed [PW-1:0]    term;
  logic [16:0]             mix_c;
  logic signed [VEC_W:0]   mix_p, mix_q;
  logic signed [PW-1:0]    mix_val;
  logic signed [PW-1:0]    mix_sat;
  logic signed [RAW_W-1:0] a_sel;
  logic [RAW_W-1:0]        a_mag;
  logic signed [RAW_W-1:0] sq_sel;
  logic signed [CB-1:0]    y_rnd, a_rnd, b_rnd;
  logic signed [CW-1:0]    dx, dy;
  logic signed [PW-1:0]    zr, zc;
  logic                    accept;

  ictf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign accept = sample.valid & sample.ready;
  assign angle.valid     = out_valid;
  assign angle.roll_deg  = roll_q;
  assign angle.pitch_deg = pitch_q;

  // rotation operand pairs: Z step, then Y, then X
  always_comb begin
    case (k)
      5'd0:    begin v_sel = rot[1]; raw_sel = 17'(gx);  end
      5'd1:    begin v_sel = rot[0]; raw_sel = 17'(gx);  end
      5'd2:    begin v_sel = rot[2]; raw_sel = -17'(gz); end
      5'd3:    begin v_sel = rot[0]; raw_sel = -17'(gz); end
      5'd4:    begin v_sel = rot[2]; raw_sel = 17'(gy);  end
      default: begin v_sel = rot[1]; raw_sel = 17'(gy);  end
    endcase
  end

  assign term = rshr(mul_q, 32);

  // low-pass and blend operands
  always_comb begin
    case (mk)
      MIX_GYRO: begin
        mix_c = weight(lowpass_alpha);
        mix_p = (VEC_W+1)'(rot[mi]);
        mix_q = (VEC_W+1)'(gyro_vec[mi]);
      end
      MIX_ACCEL: begin
        mix_c = weight(lowpass_alpha);
        mix_p = (VEC_W+1)'(accel_vec[mi]);
        mix_q = (VEC_W+1)'(an[mi]);
      end
      default: begin
        mix_c = weight(blend_alpha);
        mix_p = (VEC_W+1)'(gyro_vec[mi]);
        mix_q = (VEC_W+1)'(accel_vec[mi]);
      end
    endcase
  end

  assign mix_val = rshr(mul_q + (PW'(mix_q) <<< 15), 15);
  assign mix_sat = (mk == MIX_ACCEL) ? sat_w(mix_val, ACC_W) : sat_w(mix_val, VEC_W);

  // unit vector order is (y, z, x) of the sensor
  always_comb begin
    case (mi)
      2'd0:    a_sel = ay;
      2'd1:    a_sel = az;
      default: a_sel = ax;
    endcase
  end
  assign a_mag = a_sel[RAW_W-1] ? RAW_W'(-a_sel) : RAW_W'(a_sel);

  always_comb begin
    case (k)
      5'd0:    sq_sel = ax;
      5'd1:    sq_sel = ay;
      default: sq_sel = az;
    endcase
  end

  // roll: atan2(F1, |F0,F2|); pitch: atan2(F0, |F1,F2|)
  assign y_rnd = CB'(rshr(PW'(tp ? fused_vec[0] : fused_vec[1]), TD));
  assign a_rnd = CB'(rshr(PW'(tp ? fused_vec[1] : fused_vec[0]), TD));
  assign b_rnd = CB'(rshr(PW'(fused_vec[2]), TD));

  assign dx = cy >>> k;
  assign dy = cx >>> k;
  assign zr = rshr(PW'(cz), ROUND_Z);
  assign zc = (zr > ANG_LIM) ? ANG_LIM : ((zr < -ANG_LIM) ? -ANG_LIM : zr);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (accept) state_next = ST_ROT_P;
      ST_ROT_P:     state_next = ST_ROT_S;
      ST_ROT_S:     state_next = ST_ROT_T;
      ST_ROT_T:     state_next = (k == 5'(ROT_STEPS - 1)) ? ST_ACC_MUL : ST_ROT_P;
      ST_ACC_MUL:   state_next = ST_ACC_ADD;
      ST_ACC_ADD:   state_next = (k == 5'd2) ? ST_ASQ_GO : ST_ACC_MUL;
      ST_ASQ_GO:    state_next = (acc == '0) ? ST_MIX_MUL : ST_ASQ_WAIT;
      ST_ASQ_WAIT:  if (sq_done) state_next = ST_DIV_INIT;
      ST_DIV_INIT:  state_next = ST_DIV;
      ST_DIV:       if (k == '0) state_next = ST_DIV_END;
      ST_DIV_END:   state_next = (mi == 2'd2) ? ST_MIX_MUL : ST_DIV_INIT;
      ST_MIX_MUL:   state_next = ST_MIX_WR;
      ST_MIX_WR: begin
        if (mi == 2'd2 && mk == MIX_FUSED) state_next = ST_TILT_INIT;
        else state_next = ST_MIX_MUL;
      end
      ST_TILT_INIT: state_next = (y_rnd == '0) ? ST_TILT_END : ST_TILT_MUL;
      ST_TILT_MUL:  state_next = ST_TILT_ADD;
      ST_TILT_ADD:  state_next = (k == 5'd1) ? ST_TSQ_GO : ST_TILT_MUL;
      ST_TSQ_GO:    state_next = ST_TSQ_WAIT;
      ST_TSQ_WAIT:  if (sq_done) state_next = ST_CORDIC;
      ST_CORDIC:    if (k == 5'(CORDIC_STEPS - 1)) state_next = ST_TILT_END;
      ST_TILT_END:  state_next = tp ? ST_DONE : ST_TILT_INIT;
      ST_DONE:      if (!out_valid || angle.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, root start, multiplier operands
  always_comb begin
    sample.ready = (state == ST_IDLE);
    sq_start     = (state == ST_TSQ_GO) || (state == ST_ASQ_GO && acc != '0);
    sq_rad       = (state == ST_ASQ_GO) ? (RAD_W'(acc) << 30) : (RAD_W'(acc) << 24);
    mul_a        = '0;
    mul_b        = '0;
    case (state)
      ST_ROT_P: begin
        mul_a = MA'(v_sel);
        mul_b = MB'(raw_sel);
      end
      ST_ROT_S: begin
        mul_a = MA'(mul_q);
        mul_b = MB'($signed({1'b0, gyro_step_scale}));
      end
      ST_ACC_MUL: begin
        mul_a = MA'(sq_sel);
        mul_b = MB'(sq_sel);
      end
      ST_MIX_MUL: begin
        mul_a = MA'(mix_p - mix_q);
        mul_b = MB'($signed(mix_c));
      end
      ST_TILT_MUL: begin
        mul_a = MA'((k == '0) ? ta_r : tb_r);
        mul_b = MB'((k == '0) ? ta_r : tb_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // the one shared multiplier, registered
  always_ff @(posedge clk) begin
    mul_q <= PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      lowpass_alpha   <= LOWPASS_RST;
      blend_alpha     <= BLEND_RST;
      gyro_step_scale <= STEP_SCALE_RST;
      for (int i = 0; i < 3; i++) begin
        gyro_vec[i]  <= '0;
        accel_vec[i] <= '0;
        fused_vec[i] <= '0;
      end
      k         <= '0;
      mi        <= '0;
      mk        <= MIX_GYRO;
      tp        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (write_en) begin
        case (reg_index)
          REG_LOWPASS:    lowpass_alpha   <= write_data;
          REG_BLEND:      blend_alpha     <= write_data;
          REG_STEP_SCALE: gyro_step_scale <= write_data;
          default:        ;
        endcase
      end

      if (state == ST_DONE && (!out_valid || angle.ready)) begin
        out_valid <= 1'b1;
        roll_q    <= roll_r;
        pitch_q   <= pitch_r;
      end else if (angle.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            gx     <= sample.gyro_x;
            gy     <= sample.gyro_y;
            gz     <= sample.gyro_z;
            ax     <= sample.accel_x;
            ay     <= sample.accel_y;
            az     <= sample.accel_z;
            rot[0] <= fused_vec[0];
            rot[1] <= fused_vec[1];
            rot[2] <= fused_vec[2];
            acc    <= '0;
            k      <= '0;
          end
        end
        ST_ROT_T: begin
          // even step holds the first term of a pair, odd step updates both axes
          case (k)
            5'd1: begin
              rot[0] <= VEC_W'(sat_w(PW'(rot[0]) - PW'(t0), VEC_W));
              rot[1] <= VEC_W'(sat_w(PW'(rot[1]) + term, VEC_W));
            end
            5'd3: begin
              rot[0] <= VEC_W'(sat_w(PW'(rot[0]) + PW'(t0), VEC_W));
              rot[2] <= VEC_W'(sat_w(PW'(rot[2]) - term, VEC_W));
            end
            5'd5: begin
              rot[1] <= VEC_W'(sat_w(PW'(rot[1]) - PW'(t0), VEC_W));
              rot[2] <= VEC_W'(sat_w(PW'(rot[2]) + term, VEC_W));
            end
            default: t0 <= VEC_W'(term);
          endcase
          k <= (k == 5'(ROT_STEPS - 1)) ? '0 : k + 5'd1;
        end
        ST_ACC_ADD: begin
          acc <= acc + AW'(mul_q);
          k   <= (k == 5'd2) ? '0 : k + 5'd1;
        end
        ST_ASQ_GO: begin
          mi <= '0;
          mk <= MIX_GYRO;
          if (acc == '0) begin
            an[0] <= '0;
            an[1] <= '0;
            an[2] <= '0;
          end
        end
        ST_ASQ_WAIT: begin
          if (sq_done) r2 <= sq_root;
        end
        ST_DIV_INIT: begin
          rem  <= (DW'(a_mag) << (VECTOR_FRAC_BITS + 16)) + DW'(r2);
          dsh  <= DW'(r2) << (VECTOR_FRAC_BITS + 1);
          qacc <= '0;
          k    <= 5'(QB - 1);
        end
        ST_DIV: begin
          if (rem >= dsh) begin
            rem  <= rem - dsh;
            qacc <= {qacc[QB-2:0], 1'b1};
          end else begin
            qacc <= {qacc[QB-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          k   <= k - 5'd1;
        end
        ST_DIV_END: begin
          an[mi] <= a_sel[RAW_W-1] ? -$signed(ACC_W'(qacc)) : $signed(ACC_W'(qacc));
          mi     <= (mi == 2'd2) ? '0 : mi + 2'd1;
          mk     <= MIX_GYRO;
        end
        ST_MIX_WR: begin
          case (mk)
            MIX_GYRO:  gyro_vec[mi]  <= VEC_W'(mix_sat);
            MIX_ACCEL: accel_vec[mi] <= ACC_W'(mix_sat);
            default:   fused_vec[mi] <= VEC_W'(mix_sat);
          endcase
          if (mk == MIX_FUSED) begin
            mk <= MIX_GYRO;
            mi <= mi + 2'd1;
          end else begin
            mk <= mk + 2'd1;
          end
          tp <= 1'b0;
        end
        ST_TILT_INIT: begin
          ty_r <= y_rnd;
          ta_r <= a_rnd;
          tb_r <= b_rnd;
          cz   <= '0;
          acc  <= '0;
          k    <= '0;
        end
        ST_TILT_ADD: begin
          acc <= acc + AW'(mul_q);
          k   <= k + 5'd1;
        end
        ST_TSQ_WAIT: begin
          if (sq_done) begin
            cx <= CW'({1'b0, sq_root, 16'd0});
            cy <= CW'(ty_r) <<< 28;
            k  <= '0;
          end
        end
        ST_CORDIC: begin
          if (!cy[CW-1]) begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + ZW'(ATAN_DEG_Q20[k]);
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - ZW'(ATAN_DEG_Q20[k]);
          end
          k <= k + 5'd1;
        end
        ST_TILT_END: begin
          if (tp) pitch_r <= OUT_W'(zc);
          else roll_r <= OUT_W'(zc);
          tp <= ~tp;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: sim/tb_imu_complementary_tilt_filter_top.sv
// Testbench of the complementary tilt filter: directed corner cases, then random samples.
// Depends on ictf_pkg, ictf_if and the top level imu_complementary_tilt_filter_top.
// Expected angles come from a bit-exact predictor kept inside this bench.
module tb_imu_complementary_tilt_filter_top;
  import ictf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VFRAC = 14;
  localparam int AFRAC = 8;
  localparam int VEC_W = VFRAC + 4;
  localparam int ACC_W = VFRAC + 2;
  localparam int OUT_W = AFRAC + 8;
  // index past the register list: the block must ignore it
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct {
    shortint gx, gy, gz, ax, ay, az;
  } imu_sample_t;

  typedef struct {
    logic [OUT_W-1:0] roll;
    logic [OUT_W-1:0] pitch;
  } tilt_pair_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             write_en = 1'b0;
  logic [1:0]       reg_index = '0;
  logic [CFG_W-1:0] write_data = '0;

  ictf_sample_if              sample_ch ();
  ictf_angle_if #(.OUT_W(OUT_W)) angle_ch ();

  imu_complementary_tilt_filter_top #(
    .VECTOR_FRAC_BITS(VFRAC),
    .ANGLE_FRAC_BITS (AFRAC)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .write_en  (write_en),
    .reg_index (reg_index),
    .write_data(write_data),
    .sample    (sample_ch.sink),
    .angle     (angle_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the weights and the three kept vectors
  // ---------------------------------------------------------------------------
  longint unsigned lp_weight, blend_weight, step_scale;
  longint          gyro_lp [3];
  longint          accel_lp [3];
  longint          fused_vec [3];

  tilt_pair_t angle_q [$];
  int         mismatches = 0;
  int         stray_results = 0;
  bit         calm = 1'b0;   // when set, neither side idles

  function automatic longint sat_w(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // rounding shift, ties away from zero
  function automatic longint round_shr(longint v, int s);
    longint unsigned m;
    if (s <= 0) return v;
    m = v < 0 ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // v * raw * scale / 2^32, rounded, split so nothing overflows
  function automatic longint gyro_term(longint v, longint raw);
    longint          p;
    longint unsigned m, a, b, q;
    p = v * raw;
    m = p < 0 ? longint'(-p) : longint'(p);
    a = (m >> 16) * step_scale;
    b = (m & 64'hFFFF) * step_scale;
    q = (a + 64'd32768 + (b >> 16)) >> 16;
    return p < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint weigh(longint unsigned w, longint p, longint q);
    longint c;
    c = w > ONE_Q15 ? ONE_Q15 : longint'(w);
    return round_shr(c * p + (ONE_Q15 - c) * q, 15);
  endfunction

  function automatic longint unit_part(longint a, longint unsigned r2);
    longint unsigned m, q;
    m = a < 0 ? longint'(-a) : longint'(a);
    q = ((m << (VFRAC + 15)) * 2 + r2) / (2 * r2);
    return sat_w(a < 0 ? -longint'(q) : longint'(q), ACC_W);
  endfunction

  // atan2(num, sqrt(p^2 + q^2)) in degrees, vectoring CORDIC
  function automatic logic [OUT_W-1:0] tilt_angle(longint num, longint p, longint q);
    int              d;
    longint          yr, pr, qr, x, yy, z, dx, dy, r, lim;
    longint unsigned sum;
    d = VFRAC > 16 ? VFRAC - 16 : 0;
    yr = round_shr(num, d);
    pr = round_shr(p, d);
    qr = round_shr(q, d);
    if (yr == 0) return '0;
    sum = longint'(pr * pr) + longint'(qr * qr);
    x = longint'(int_sqrt(sum << 24)) * 65536;
    yy = yr * (64'sd1 <<< 28);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = yy >>> i;
      dy = x >>> i;
      if (yy >= 0) begin
        x += dx; yy -= dy; z += longint'(ATAN_DEG_Q20[i]);
      end else begin
        x -= dx; yy += dy; z -= longint'(ATAN_DEG_Q20[i]);
      end
    end
    r = round_shr(z, TABLE_FRAC - AFRAC);
    lim = 64'sd90 <<< AFRAC;
    r = r > lim ? lim : (r < -lim ? -lim : r);
    return r[OUT_W-1:0];
  endfunction

  task automatic predict_tilt(input imu_sample_t s);
    longint          vx, vy, vz, x1, y1, x2, z2, y3, z3;
    longint          rot [3];
    longint          unit [3];
    longint unsigned ss, r2;
    tilt_pair_t      e;
    vx = fused_vec[0]; vy = fused_vec[1]; vz = fused_vec[2];
    // small-angle rotations about Z (gyro_x), Y (-gyro_z), X (gyro_y)
    x1 = sat_w(vx - gyro_term(vy, s.gx), VEC_W);
    y1 = sat_w(vy + gyro_term(vx, s.gx), VEC_W);
    x2 = sat_w(x1 + gyro_term(vz, -longint'(s.gz)), VEC_W);
    z2 = sat_w(vz - gyro_term(x1, -longint'(s.gz)), VEC_W);
    y3 = sat_w(y1 - gyro_term(z2, s.gy), VEC_W);
    z3 = sat_w(z2 + gyro_term(y1, s.gy), VEC_W);
    rot[0] = x2; rot[1] = y3; rot[2] = z3;
    ss = longint'(longint'(s.ax) * s.ax) + longint'(longint'(s.ay) * s.ay)
       + longint'(longint'(s.az) * s.az);
    if (ss == 0) begin
      unit[0] = 0; unit[1] = 0; unit[2] = 0;
    end else begin
      r2 = int_sqrt(ss << 30);
      unit[0] = unit_part(s.ay, r2);
      unit[1] = unit_part(s.az, r2);
      unit[2] = unit_part(s.ax, r2);
    end
    for (int i = 0; i < 3; i++) begin
      gyro_lp[i]   = sat_w(weigh(lp_weight, rot[i], gyro_lp[i]), VEC_W);
      accel_lp[i]  = sat_w(weigh(lp_weight, accel_lp[i], unit[i]), ACC_W);
      fused_vec[i] = sat_w(weigh(blend_weight, gyro_lp[i], accel_lp[i]), VEC_W);
    end
    e.roll  = tilt_angle(fused_vec[1], fused_vec[0], fused_vec[2]);
    e.pitch = tilt_angle(fused_vec[0], fused_vec[1], fused_vec[2]);
    angle_q.push_back(e);
  endtask

  // ---------------------------------------------------------------------------
  // Angle sink: random back-pressure, mostly short stalls, a few long ones
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  initial angle_ch.ready = 1'b0;

  always @(posedge clk) begin
    int r;
    if (rst) begin
      angle_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left     <= stall_left - 1;
      angle_ch.ready <= 1'b0;
    end else begin
      angle_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (!calm && r < 14) stall_left <= $urandom_range(1, 4);
      else if (!calm && r < 16) stall_left <= $urandom_range(40, 200);
    end
  end

  // result checker: each accepted angle pair against the oldest expectation
  always @(posedge clk) begin
    tilt_pair_t e;
    if (!rst && angle_ch.valid && angle_ch.ready) begin
      if (angle_q.size() == 0) begin
        stray_results++;
        $display("unexpected angle request: roll %0d pitch %0d",
                 angle_ch.roll_deg, angle_ch.pitch_deg);
      end else begin
        e = angle_q.pop_front();
        if (angle_ch.roll_deg !== e.roll || angle_ch.pitch_deg !== e.pitch) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle mismatch: roll exp %0d got %0d, pitch exp %0d got %0d",
                     $signed(e.roll), angle_ch.roll_deg,
                     $signed(e.pitch), angle_ch.pitch_deg);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample source
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // one request on the sample channel; valid stays high when no gap follows
  task automatic send_sample(input imu_sample_t s);
    int gap;
    sample_ch.valid   <= 1'b1;
    sample_ch.gyro_x  <= s.gx;
    sample_ch.gyro_y  <= s.gy;
    sample_ch.gyro_z  <= s.gz;
    sample_ch.accel_x <= s.ax;
    sample_ch.accel_y <= s.ay;
    sample_ch.accel_z <= s.az;
    do @(posedge clk); while (!sample_ch.ready);
    predict_tilt(s);
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every angle has come back, then lets the block settle
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (angle_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    write_en   <= 1'b1;
    reg_index  <= idx;
    write_data <= val;
    @(posedge clk);
    write_en <= 1'b0;
    case (idx)
      REG_LOWPASS:    lp_weight    = val;
      REG_BLEND:      blend_weight = val;
      REG_STEP_SCALE: step_scale   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic imu_sample_t mk(int gx, int gy, int gz, int ax, int ay, int az);
    imu_sample_t s;
    s.gx = shortint'(gx); s.gy = shortint'(gy); s.gz = shortint'(gz);
    s.ax = shortint'(ax); s.ay = shortint'(ay); s.az = shortint'(az);
    return s;
  endfunction

  function automatic shortint rand_raw(int span);
    return shortint'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic imu_sample_t rand_sample();
    imu_sample_t s;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      // pure noise over the whole field range
      s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      // slow rotation with an accelerometer near 1 g plus jitter, now and then all zero
      s.gx = rand_raw(r < 60 ? 300 : 3000);
      s.gy = rand_raw(r < 60 ? 300 : 3000);
      s.gz = rand_raw(r < 60 ? 300 : 3000);
      s.ax = rand_raw(9000);
      s.ay = rand_raw(9000);
      s.az = shortint'(16384 + rand_raw(6000));
      if (r > 95) begin
        s.ax = 0; s.ay = 0; s.az = 0;
      end
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_special_cases();
    // both angles from an all-zero state: atan2(0,0)
    send_sample(mk(0, 0, 0, 0, 0, 0));
    // gravity on one axis only: the roll denominator is zero, roll goes to 90
    send_sample(mk(0, 0, 0, 0, 0, 16384));
    send_sample(mk(0, 0, 0, 0, 0, 16384));
    send_sample(mk(0, 0, 0, 0, 0, -32768));
    // full-scale extremes of every field
    send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(mk(32767, -32768, 32767, -32768, 32767, -32768));
    send_sample(mk(-32768, 32767, -32768, 32767, -32768, 32767));
    // each gyro axis alone, with a zero accelerometer vector
    send_sample(mk(20000, 0, 0, 0, 0, 0));
    send_sample(mk(0, -20000, 0, 0, 0, 0));
    send_sample(mk(0, 0, 20000, 0, 0, 0));
    send_sample(mk(-1, 1, -1, 1, -1, 1));
    drain();
  endtask

  task automatic test_weight_extremes();
    // full low-pass memory, pure gyro blend, largest step scale
    write_reg(REG_LOWPASS, 16'd0);
    write_reg(REG_BLEND, 16'd32768);
    write_reg(REG_STEP_SCALE, 16'hFFFF);
    send_sample(mk(0, 0, 0, 12000, -5000, 14000));
    send_sample(mk(32767, -32768, 12345, 8000, 0, 16000));
    send_sample(mk(-700, 900, -32768, -30000, 20000, 100));
    drain();
    // weights above one clamp; zero step scale freezes the rotation
    write_reg(REG_LOWPASS, 16'hFFFF);
    write_reg(REG_BLEND, 16'd0);
    write_reg(REG_STEP_SCALE, 16'd0);
    write_reg(REG_SPARE, 16'hA5A5);
    send_sample(mk(32767, 32767, 32767, 0, 16384, 0));
    send_sample(mk(-32768, 0, 5, 4000, -4000, 16000));
    drain();
    write_reg(REG_LOWPASS, 16'd32768);
    write_reg(REG_BLEND, 16'hFFFF);
    send_sample(mk(1000, -1000, 500, 16000, 0, 0));
    send_sample(mk(-1000, 1000, -500, -16000, 0, 0));
    drain();
    write_reg(REG_LOWPASS, LOWPASS_RST);
    write_reg(REG_BLEND, BLEND_RST);
    write_reg(REG_STEP_SCALE, STEP_SCALE_RST);
  endtask

  task automatic test_random_stream(input int count);
    int n;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        // in-range weights most of the time, now and then above one
        write_reg(REG_LOWPASS, CFG_W'($urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(0, 32768)));
        write_reg(REG_BLEND, CFG_W'($urandom_range(0, 3) == 0 ? $urandom
                                                             : $urandom_range(0, 32768)));
        write_reg(REG_STEP_SCALE, CFG_W'($urandom_range(0, 1) ? $urandom
                                                             : $urandom_range(0, 8000)));
      end
      calm = (phase == 2);
      n = count / 6;
      for (int i = 0; i < n; i++) begin
        send_sample(rand_sample());
        if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    lp_weight    = LOWPASS_RST;
    blend_weight = BLEND_RST;
    step_scale   = STEP_SCALE_RST;
    for (int i = 0; i < 3; i++) begin
      gyro_lp[i] = 0; accel_lp[i] = 0; fused_vec[i] = 0;
    end
    sample_ch.valid   = 1'b0;
    sample_ch.gyro_x  = '0;
    sample_ch.gyro_y  = '0;
    sample_ch.gyro_z  = '0;
    sample_ch.accel_x = '0;
    sample_ch.accel_y = '0;
    sample_ch.accel_z = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_cases();
    test_weight_extremes();
    test_random_stream(1320);

    while (angle_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && stray_results == 0 && angle_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #100ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: imu_complementary_tilt_filter_top.f
hdl/ictf_pkg.sv
hdl/ictf_if.sv
hdl/ictf_isqrt.sv
hdl/imu_complementary_tilt_filter_top.sv
sim/tb_imu_complementary_tilt_filter_top.sv
